@@ design/gnss_binary_block_deframer_assert.svh @@
// Assertion macros for the binary block deframer.
// Used by the port checker; no other dependencies.
`ifndef GNSS_BINARY_BLOCK_DEFRAMER_ASSERT_SVH
`define GNSS_BINARY_BLOCK_DEFRAMER_ASSERT_SVH

// Checked only outside reset.
`define GBBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("gbbd assertion failed");

// Checked at every edge, reset included.
`define GBBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gbbd assertion failed");

`endif

@@ design/gbbd_pkg.sv @@
// Shared types and constants for the binary block deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package gbbd_pkg;

    localparam int unsigned ID_W = 13;
    localparam logic [15:0] HEADER_SIZE = 16'd8;

    typedef enum logic [2:0] {
        K_STRAY  = 3'd0,
        K_SYNC   = 3'd1,
        K_HEADER = 3'd2,
        K_PAY    = 3'd3,
        K_EMPTY  = 3'd4,
        K_LENERR = 3'd5
    } t_kind;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_CHK_LO  = 8'b0000_0010,
        PH_CHK_HI  = 8'b0000_0100,
        PH_ID_LO   = 8'b0000_1000,
        PH_ID_HI   = 8'b0001_0000,
        PH_LEN_LO  = 8'b0010_0000,
        PH_LEN_HI  = 8'b0100_0000,
        PH_PAYLOAD = 8'b1000_0000
    } t_phase;

    localparam logic [0:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [0:0] CFG_SYNC_SECOND = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       abort;
    } t_in_item;

    typedef struct packed {
        t_kind          kind;
        logic [7:0]     data;
        logic [ID_W-1:0] block_id;
        logic [15:0]    check_word;
        logic [15:0]    frame_length;
        logic           last;
    } t_out_item;

    typedef struct packed {
        logic [0:0] reg_index;
        logic [7:0] wdata;
    } t_cfg_item;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } t_sync_cfg;

endpackage

`default_nettype wire

@@ design/gbbd_chan_if.sv @@
// Valid/ready channel carrying one payload of type t_payload.
// Used for the byte input, result output and configuration write channels.
`default_nettype none

interface gbbd_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/gnss_binary_block_deframer.sv @@
// Binary block deframer: byte stream in, tagged per-byte results out.
// Channels: i_in carries in_byte and abort; o_out carries one result per
// non-abort byte (kind, data, block_id, check_word, frame_length, last);
// i_cfg writes sync_first (index 0) and sync_second (index 1), always ready.
// Each byte passes an input register, then the frame state machine, then a
// result register: its result is presented once the core has taken it from
// the input register and loaded the result register. One byte per cycle is
// sustained while the receiver keeps taking results. An abort
// transfer drops the partial frame and gives no result. The input register
// refills in the cycle it drains, so a waiting result does not block the next
// byte until both stages are full; a stalled receiver then holds i_in.ready
// low. Reset clears the frame state and held header words, restores the sync
// bytes to 0x24 and 0x40 and empties both stages.
// Depends on gbbd_pkg, gbbd_chan_if and the three submodules.
`default_nettype none

module gnss_binary_block_deframer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gbbd_chan_if.sink   i_in,
    gbbd_chan_if.source o_out,
    gbbd_chan_if.sink   i_cfg
);
    import gbbd_pkg::*;

    t_sync_cfg sync;
    t_in_item  item;
    logic      item_valid;
    logic      take;

    gbbd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_sync  (sync)
    );

    gbbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    gbbd_frame_core u_frame_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .i_sync  (sync),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ design/gbbd_cfg_regs.sv @@
// Sync byte registers written over the configuration channel.
// Depends on gbbd_pkg and gbbd_chan_if.
`default_nettype none

module gbbd_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    gbbd_chan_if.sink                i_cfg,
    output gbbd_pkg::t_sync_cfg      o_sync
);
    import gbbd_pkg::*;

    t_sync_cfg r_sync;

    assign i_cfg.ready = 1'b1;
    assign o_sync      = r_sync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync.first  <= 8'd36;
            r_sync.second <= 8'd64;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.reg_index)
                CFG_SYNC_FIRST:  r_sync.first  <= i_cfg.payload.wdata;
                CFG_SYNC_SECOND: r_sync.second <= i_cfg.payload.wdata;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/gbbd_in_reg.sv @@
// Input register stage: holds one accepted byte until the core takes it.
// Depends on gbbd_pkg and gbbd_chan_if.
`default_nettype none

module gbbd_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    gbbd_chan_if.sink           i_in,
    input  wire logic           i_take,
    output logic                o_valid,
    output gbbd_pkg::t_in_item  o_item
);
    import gbbd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Refill in the same cycle the core drains the stage.
    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.payload;
        end
    end

endmodule

`default_nettype wire

@@ design/gbbd_frame_core.sv @@
// Frame state machine and result register of the deframer.
// Depends on gbbd_pkg and gbbd_chan_if.
`default_nettype none

module gbbd_frame_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  gbbd_pkg::t_in_item  i_item,
    input  gbbd_pkg::t_sync_cfg i_sync,
    output logic                o_take,
    gbbd_chan_if.source         o_out
);
    import gbbd_pkg::*;

    t_phase          r_phase,    n_phase;
    logic [7:0]      r_prior,    n_prior;
    logic [15:0]     r_rem,      n_rem;
    logic [15:0]     r_check,    n_check;
    logic [ID_W-1:0] r_id,       n_id;
    logic [15:0]     r_len,      n_len;
    logic [7:0]      r_low,      n_low;
    logic            r_out_valid;
    t_out_item       r_out,      n_out;
    logic [15:0]     word;
    logic [7:0]      b;

    // An abort transfer yields no result, so it never waits on the output.
    assign o_take = i_valid && (i_item.abort || !r_out_valid || o_out.ready);
    assign b      = i_item.in_byte;
    assign word   = {b, r_low};

    always_comb begin
        n_phase = r_phase;
        n_prior = r_prior;
        n_rem   = r_rem;
        n_check = r_check;
        n_id    = r_id;
        n_len   = r_len;
        n_low   = r_low;
        n_out.kind = K_STRAY;
        n_out.last = 1'b0;

        unique case (r_phase)
            PH_CHK_LO, PH_ID_LO, PH_LEN_LO: begin
                n_low      = b;
                n_out.kind = K_HEADER;
                n_phase    = t_phase'({r_phase[6:0], 1'b0});
            end
            PH_CHK_HI: begin
                n_check    = word;
                n_out.kind = K_HEADER;
                n_phase    = PH_ID_LO;
            end
            PH_ID_HI: begin
                n_id       = word[ID_W-1:0];
                n_out.kind = K_HEADER;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_HI: begin
                n_len = word;
                if (word < HEADER_SIZE) begin
                    n_out.kind = K_LENERR;
                    n_phase    = PH_HUNT;
                    n_prior    = 8'd0;
                    n_rem      = 16'd0;
                end else if (word == HEADER_SIZE) begin
                    n_out.kind = K_EMPTY;
                    n_out.last = 1'b1;
                    n_phase    = PH_HUNT;
                    n_prior    = 8'd0;
                    n_rem      = 16'd0;
                end else begin
                    n_out.kind = K_HEADER;
                    n_rem      = word - HEADER_SIZE;
                    n_phase    = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_out.kind = K_PAY;
                n_rem      = r_rem - 16'd1;
                if (n_rem == 16'd0) begin
                    n_out.last = 1'b1;
                    n_phase    = PH_HUNT;
                    n_prior    = 8'd0;
                end
            end
            default: begin
                if (r_prior == i_sync.first && b == i_sync.second) begin
                    n_out.kind = K_SYNC;
                    n_check    = 16'd0;
                    n_id       = '0;
                    n_len      = 16'd0;
                    n_low      = 8'd0;
                    n_prior    = 8'd0;
                    n_phase    = PH_CHK_LO;
                end else begin
                    n_prior = b;
                end
            end
        endcase

        n_out.data         = b;
        n_out.block_id     = n_id;
        n_out.check_word   = n_check;
        n_out.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_prior     <= 8'd0;
            r_rem       <= 16'd0;
            r_check     <= 16'd0;
            r_id        <= '0;
            r_len       <= 16'd0;
            r_low       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take && i_item.abort) begin
                r_phase <= PH_HUNT;
                r_prior <= 8'd0;
                r_rem   <= 16'd0;
            end else if (o_take) begin
                r_phase <= n_phase;
                r_prior <= n_prior;
                r_rem   <= n_rem;
                r_check <= n_check;
                r_id    <= n_id;
                r_len   <= n_len;
                r_low   <= n_low;
            end
            if (o_take && !i_item.abort) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && !i_item.abort) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

@@ design/gbbd_port_checker.sv @@
// Port-level checks for the binary block deframer, bound to the top level.
// Depends on gbbd_pkg and gnss_binary_block_deframer_assert.svh.
`default_nettype none
`include "gnss_binary_block_deframer_assert.svh"

module gbbd_port_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire gbbd_pkg::t_kind i_kind,
    input wire logic            i_last,
    input wire logic [15:0]     i_frame_length
);
    import gbbd_pkg::*;

    `GBBD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `GBBD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)
    `GBBD_ASSERT(a_last_kind, i_clk, i_rst_n, i_out_valid && i_last |-> (i_kind == K_PAY || i_kind == K_EMPTY))
    `GBBD_ASSERT(a_empty_frame, i_clk, i_rst_n, i_out_valid && i_kind == K_EMPTY |-> (i_last && i_frame_length == HEADER_SIZE))
    `GBBD_ASSERT(a_len_error, i_clk, i_rst_n, i_out_valid && i_kind == K_LENERR |-> (i_frame_length < HEADER_SIZE && !i_last))

endmodule

bind gnss_binary_block_deframer gbbd_port_checker u_port_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.payload.kind),
    .i_last         (o_out.payload.last),
    .i_frame_length (o_out.payload.frame_length)
);

`default_nettype wire
